// ===== rtl/core/cartesian_to_spherical_top_macros.svh =====
// Assertion macros shared by the cartesian-to-spherical converter RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef CARTESIAN_TO_SPHERICAL_TOP_MACROS_SVH
`define CARTESIAN_TO_SPHERICAL_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Plain property, checked outside reset
`define CTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication
`define CTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define CTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/cts_pkg.sv =====
// Shared constants for the cartesian-to-spherical converter: default widths,
// fixed-point formats, inverse CORDIC gain and the arctangent step table.
package cts_pkg;

  localparam int COORD_WIDTH_DEF  = 24;
  localparam int ANGLE_WIDTH_DEF  = 24;
  localparam int CORDIC_STEPS_DEF = 24;

  // Working values carry guard bits below and headroom above the coordinate
  localparam int GUARD_BITS    = 24;
  localparam int HEADROOM_BITS = 3;

  // Angle accumulator: 32-bit binary angle, full turn wraps
  localparam int ACC_W = 32;

  localparam logic [ACC_W-1:0] QUARTER_TURN = 32'h4000_0000;
  // 0.6072529350 * 2^32
  localparam logic [31:0]      INV_GAIN_Q32 = 32'd2608131496;

  // atan(2^-i) in 32-bit binary angle units, rounded to nearest
  localparam logic [ACC_W-1:0] ATAN_TABLE [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

endpackage

// ===== rtl/core/cartesian_to_spherical_top.sv =====
// Cartesian (x, y, z) to longitude/latitude converter: pre-rotation stage,
// two chains of cts_cell CORDIC cells, cts_gain in between, skid output.
// A point enters every clock cycle while s_axis_tready_o is high; it passes the
// pre-rotation register, the unrolled chains of 2*CORDIC_STEPS cells, the two
// gain stages and the output register. s_axis_tready_o drops only while the
// skid register holds a result that the sink has not yet taken. There is no
// configuration and no state beyond the pipeline; reset only empties it.
`include "cartesian_to_spherical_top_macros.svh"
module cartesian_to_spherical_top import cts_pkg::*; #(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // tdata: x_coord, y_coord, z_coord from the lowest bit up, zero padded
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  input  logic s_axis_tlast_i,                 // last_item
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // tdata: longitude, latitude from the lowest bit up, zero padded
  output logic [((2*ANGLE_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  output logic m_axis_tlast_o                  // last_result
);

  localparam int W       = COORD_WIDTH + GUARD_BITS + HEADROOM_BITS;
  localparam int OUT_W   = ((2*ANGLE_WIDTH+7)/8)*8;
  localparam int SIDE1_W = COORD_WIDTH + 3;      // z, xy_zero, all_zero, last
  localparam int SIDEG_W = SIDE1_W + ACC_W;      // pass-one side plus longitude
  localparam int SIDE2_W = ACC_W + 2;            // longitude, all_zero, last
  localparam int SH      = ACC_W - ANGLE_WIDTH;
  localparam logic [ACC_W-1:0] HALF_STEP = ACC_W'((64'd1 << SH) >> 1);

  logic en;

  // Unpack and scale the coordinates into working values
  logic [COORD_WIDTH-1:0] x_in, y_in, z_in;
  logic signed [W-1:0]    x_s, y_s;
  logic                   xy_zero, all_zero;

  assign x_in = s_axis_tdata_i[COORD_WIDTH-1:0];
  assign y_in = s_axis_tdata_i[2*COORD_WIDTH-1:COORD_WIDTH];
  assign z_in = s_axis_tdata_i[3*COORD_WIDTH-1:2*COORD_WIDTH];
  assign x_s  = {{HEADROOM_BITS{x_in[COORD_WIDTH-1]}}, x_in, {GUARD_BITS{1'b0}}};
  assign y_s  = {{HEADROOM_BITS{y_in[COORD_WIDTH-1]}}, y_in, {GUARD_BITS{1'b0}}};
  assign xy_zero  = (x_in == '0) && (y_in == '0);
  assign all_zero = xy_zero && (z_in == '0);

  // Turn left-half-plane points by a quarter turn
  logic signed [W-1:0] pre_a_d, pre_b_d, pre_a_q, pre_b_q;
  logic [ACC_W-1:0]    pre_acc_d, pre_acc_q;
  logic [SIDE1_W-1:0]  pre_side_q;
  logic                pre_valid_q;

  always_comb begin
    pre_a_d   = x_s;
    pre_b_d   = y_s;
    pre_acc_d = '0;
    if (x_s[W-1]) begin
      if (!y_s[W-1]) begin
        pre_a_d   = y_s;
        pre_b_d   = -x_s;
        pre_acc_d = QUARTER_TURN;
      end else begin
        pre_a_d   = -y_s;
        pre_b_d   = x_s;
        pre_acc_d = ACC_W'(0) - QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= 1'b0;
    end else if (en) begin
      pre_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pre_a_q    <= pre_a_d;
      pre_b_q    <= pre_b_d;
      pre_acc_q  <= pre_acc_d;
      pre_side_q <= {s_axis_tlast_i, all_zero, xy_zero, z_in};
    end
  end

  // Pass one: vector (x, y) onto the positive x axis
  logic                p1_valid [CORDIC_STEPS+1];
  logic signed [W-1:0] p1_a     [CORDIC_STEPS+1];
  logic signed [W-1:0] p1_b     [CORDIC_STEPS+1];
  logic [ACC_W-1:0]    p1_acc   [CORDIC_STEPS+1];
  logic [SIDE1_W-1:0]  p1_side  [CORDIC_STEPS+1];

  assign p1_valid[0] = pre_valid_q;
  assign p1_a[0]     = pre_a_q;
  assign p1_b[0]     = pre_b_q;
  assign p1_acc[0]   = pre_acc_q;
  assign p1_side[0]  = pre_side_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_pass1
    cts_cell #(.W(W), .STEP(i), .SIDE_W(SIDE1_W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (p1_valid[i]),
      .a_i     (p1_a[i]),
      .b_i     (p1_b[i]),
      .acc_i   (p1_acc[i]),
      .side_i  (p1_side[i]),
      .valid_o (p1_valid[i+1]),
      .a_o     (p1_a[i+1]),
      .b_o     (p1_b[i+1]),
      .acc_o   (p1_acc[i+1]),
      .side_o  (p1_side[i+1])
    );
  end

  // Force longitude to zero at the planar origin, then correct the gain
  logic [ACC_W-1:0]   lon_acc;
  logic [W-1:0]       g_mag;
  logic [SIDEG_W-1:0] g_side;
  logic               g_valid;
  logic               p1_residue;

  assign lon_acc    = p1_side[CORDIC_STEPS][COORD_WIDTH] ? '0 : p1_acc[CORDIC_STEPS];
  assign p1_residue = ^p1_b[CORDIC_STEPS];

  cts_gain #(.W(W), .SIDE_W(SIDEG_W)) u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p1_valid[CORDIC_STEPS]),
    .mag_i   (p1_a[CORDIC_STEPS]),
    .side_i  ({p1_side[CORDIC_STEPS], lon_acc}),
    .valid_o (g_valid),
    .mag_o   (g_mag),
    .side_o  (g_side)
  );

  // Pass two: vector (magnitude, z) for the latitude
  logic [COORD_WIDTH-1:0] g_z;
  logic                   p2_valid [CORDIC_STEPS+1];
  logic signed [W-1:0]    p2_a     [CORDIC_STEPS+1];
  logic signed [W-1:0]    p2_b     [CORDIC_STEPS+1];
  logic [ACC_W-1:0]       p2_acc   [CORDIC_STEPS+1];
  logic [SIDE2_W-1:0]     p2_side  [CORDIC_STEPS+1];

  assign g_z         = g_side[ACC_W +: COORD_WIDTH];
  assign p2_valid[0] = g_valid;
  assign p2_a[0]     = signed'(g_mag);
  assign p2_b[0]     = {{HEADROOM_BITS{g_z[COORD_WIDTH-1]}}, g_z, {GUARD_BITS{1'b0}}};
  assign p2_acc[0]   = '0;
  assign p2_side[0]  = {g_side[SIDEG_W-1], g_side[SIDEG_W-2], g_side[ACC_W-1:0]};

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_pass2
    cts_cell #(.W(W), .STEP(i), .SIDE_W(SIDE2_W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (p2_valid[i]),
      .a_i     (p2_a[i]),
      .b_i     (p2_b[i]),
      .acc_i   (p2_acc[i]),
      .side_i  (p2_side[i]),
      .valid_o (p2_valid[i+1]),
      .a_o     (p2_a[i+1]),
      .b_o     (p2_b[i+1]),
      .acc_o   (p2_acc[i+1]),
      .side_o  (p2_side[i+1])
    );
  end

  // Round both angles to the output width
  logic [ACC_W-1:0]       lat_acc, lon_sum, lat_sum;
  logic [ANGLE_WIDTH-1:0] fin_lon, fin_lat;
  logic                   fin_last, fin_valid;
  logic                   p2_residue;

  assign lat_acc    = p2_side[CORDIC_STEPS][ACC_W] ? '0 : p2_acc[CORDIC_STEPS];
  assign lon_sum    = p2_side[CORDIC_STEPS][ACC_W-1:0] + HALF_STEP;
  assign lat_sum    = lat_acc + HALF_STEP;
  assign fin_lon    = lon_sum[ACC_W-1:SH];
  assign fin_lat    = lat_sum[ACC_W-1:SH];
  assign fin_last   = p2_side[CORDIC_STEPS][ACC_W+1];
  assign fin_valid  = p2_valid[CORDIC_STEPS];
  assign p2_residue = ^{p2_a[CORDIC_STEPS], p2_b[CORDIC_STEPS]};

  // Output register with skid: the pipeline stalls only while the skid is full
  logic                   out_valid_d, out_valid_q, skid_valid_d, skid_valid_q;
  logic [ANGLE_WIDTH-1:0] out_lon_d, out_lon_q, out_lat_d, out_lat_q;
  logic [ANGLE_WIDTH-1:0] skid_lon_d, skid_lon_q, skid_lat_d, skid_lat_q;
  logic                   out_last_d, out_last_q, skid_last_d, skid_last_q;
  logic                   take;

  assign en   = !skid_valid_q;
  assign take = out_valid_q && m_axis_tready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_lon_d    = out_lon_q;
    out_lat_d    = out_lat_q;
    out_last_d   = out_last_q;
    skid_valid_d = skid_valid_q;
    skid_lon_d   = skid_lon_q;
    skid_lat_d   = skid_lat_q;
    skid_last_d  = skid_last_q;
    if (skid_valid_q) begin
      // Drain the skid once the sink takes the current result
      if (take) begin
        out_lon_d    = skid_lon_q;
        out_lat_d    = skid_lat_q;
        out_last_d   = skid_last_q;
        skid_valid_d = 1'b0;
      end
    end else if (fin_valid) begin
      if (!out_valid_q || take) begin
        out_valid_d = 1'b1;
        out_lon_d   = fin_lon;
        out_lat_d   = fin_lat;
        out_last_d  = fin_last;
      end else begin
        skid_valid_d = 1'b1;
        skid_lon_d   = fin_lon;
        skid_lat_d   = fin_lat;
        skid_last_d  = fin_last;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_lon_q   <= out_lon_d;
    out_lat_q   <= out_lat_d;
    out_last_q  <= out_last_d;
    skid_lon_q  <= skid_lon_d;
    skid_lat_q  <= skid_lat_d;
    skid_last_q <= skid_last_d;
  end

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({out_lat_q, out_lon_q});
  assign m_axis_tlast_o  = out_last_q;

  // Final residues and the planar-origin flag dropped before pass two feed no logic
  logic unused_ok;
  assign unused_ok = p1_residue ^ p2_residue ^ g_side[SIDEG_W-3];

  `CTS_ASSERT_IMP(a_skid_needs_out, clk_i, rst_ni, skid_valid_q, out_valid_q,
                  "skid holds a result while the output register is empty")
  `CTS_ASSERT_IMP(a_skid_fill_on_stall, clk_i, rst_ni, $rose(skid_valid_q),
                  $past(out_valid_q && !m_axis_tready_i),
                  "skid filled without a stalled output")
  `CTS_ASSERT_NXT(a_stall_keeps_result, clk_i, rst_ni,
                  en && fin_valid && out_valid_q && !m_axis_tready_i, skid_valid_q,
                  "finished result dropped while output stalled")

endmodule

// ===== rtl/core/cts_cell.sv =====
// One CORDIC vectoring micro-rotation cell with its pipeline register.
// Depends on cts_pkg for the arctangent table and accumulator width.
module cts_cell import cts_pkg::*; #(
  parameter int W      = 51,
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  input  logic [ACC_W-1:0]    acc_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic signed [W-1:0] a_o,
  output logic signed [W-1:0] b_o,
  output logic [ACC_W-1:0]    acc_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam logic [ACC_W-1:0] STEP_ANGLE = ATAN_TABLE[STEP];

  logic signed [W-1:0] da, db;
  logic signed [W-1:0] a_d, b_d, a_q, b_q;
  logic [ACC_W-1:0]    acc_d, acc_q;
  logic [SIDE_W-1:0]   side_q;
  logic                valid_q;

  // Rotate toward the positive a axis, steering on the sign of b
  always_comb begin
    da = b_i >>> STEP;
    db = a_i >>> STEP;
    if (!b_i[W-1]) begin
      a_d   = a_i + da;
      b_d   = b_i - db;
      acc_d = acc_i + STEP_ANGLE;
    end else begin
      a_d   = a_i - da;
      b_d   = b_i + db;
      acc_d = acc_i - STEP_ANGLE;
    end
  end

  // Hold the valid flag under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_d;
      b_q    <= b_d;
      acc_q  <= acc_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign acc_o   = acc_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/core/cts_gain.sv =====
// Inverse CORDIC gain correction: two-stage multiply of the horizontal
// magnitude by 0.60725 in Q32, split into low and high partial products.
// Depends on cts_pkg for the inverse gain constant.
module cts_gain import cts_pkg::*; #(
  parameter int W      = 51,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [W-1:0]      mag_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [W-1:0]      mag_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [63:0]       lo_prod;
  logic [W-1:0]      hi_prod;
  logic [31:0]       lo_q;
  logic [W-1:0]      hi_q, mag_q;
  logic [SIDE_W-1:0] side1_q, side2_q;
  logic              valid1_q, valid2_q;

  // Partial products: low 32 bits and the remaining high bits
  assign lo_prod = 64'(mag_i[31:0]) * 64'(INV_GAIN_Q32);
  assign hi_prod = W'(mag_i[W-1:32]) * W'(INV_GAIN_Q32);

  // Hold the valid flags under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  // Register partial products, then sum them
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q    <= lo_prod[63:32];
      hi_q    <= hi_prod;
      side1_q <= side_i;
      mag_q   <= hi_q + W'(lo_q);
      side2_q <= side1_q;
    end
  end

  assign valid_o = valid2_q;
  assign mag_o   = mag_q;
  assign side_o  = side2_q;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for cartesian_to_spherical_top: streams points in,
// predicts longitude/latitude with a bit-exact CORDIC model and checks every transfer.
// Depends on cts_pkg for the default widths and on the converter RTL.
module tb_top import cts_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW          = COORD_WIDTH_DEF;
  localparam int AW          = ANGLE_WIDTH_DEF;
  localparam int STEPS       = CORDIC_STEPS_DEF;
  localparam int S_DATA_W    = ((3*CW+7)/8)*8;
  localparam int M_DATA_W    = ((2*AW+7)/8)*8;
  localparam int LATENCY     = 2*STEPS+4;
  localparam int HOLD_OFF    = 400;
  localparam int STALL_LIMIT = 5000;

  // Fixed-point formats of the working values and the angle accumulator
  localparam int                GUARD    = 24;
  localparam logic [31:0]       QTURN    = 32'h4000_0000;
  localparam longint unsigned   INV_GAIN = 64'd2608131496;
  localparam logic [31:0]       ATAN_STEP [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [AW-1:0] angle_t;
  typedef struct packed {
    angle_t lon;
    angle_t lat;
    logic   last;
  } sph_result_t;

  localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};

  logic                clk_i   = 1'b0;
  logic                rst_n   = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [S_DATA_W-1:0] s_data  = '0;
  logic                s_last  = 1'b0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [M_DATA_W-1:0] m_data;
  logic                m_last;

  sph_result_t pending_angles[$];
  bit          src_idle_en  = 1'b1;
  bit          sink_idle_en = 1'b1;
  bit          hold_request = 1'b0;
  int          hold_left    = 0;
  int          idle_cycles  = 0;
  int          errors       = 0;
  int          points_sent  = 0;
  int          results_seen = 0;
  int          input_stalls = 0;

  cartesian_to_spherical_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Drive the vectoring recurrence: rotate (a, b) for STEPS iterations, driving b toward zero
  function automatic logic [31:0] cordic_vectoring(inout longint a, inout longint b,
                                                   input logic [31:0] acc);
    longint da, db;
    for (int i = 0; i < STEPS; i++) begin
      da = b >>> (i & 31);
      db = a >>> (i & 31);
      if (b >= 0) begin
        a   = a + da;
        b   = b - db;
        acc = acc + ATAN_STEP[i & 31];
      end else begin
        a   = a - da;
        b   = b + db;
        acc = acc - ATAN_STEP[i & 31];
      end
    end
    return acc;
  endfunction

  // Round a 32-bit binary angle to the output width, wrapping
  function automatic angle_t round_angle(logic [31:0] acc);
    logic [32:0] t;
    t = {1'b0, acc} + (33'd1 << (31 - AW));
    return angle_t'(t >> (32 - AW));
  endfunction

  function automatic sph_result_t predict_spherical(coord_t x, coord_t y, coord_t z,
                                                    logic last);
    longint          px, py, pz, a, b, mag;
    longint unsigned u;
    logic [31:0]     lon, lat, start;
    sph_result_t     r;
    px  = longint'(x) <<< GUARD;
    py  = longint'(y) <<< GUARD;
    pz  = longint'(z) <<< GUARD;
    lon = '0;
    lat = '0;
    mag = 0;
    // Pass one: longitude and horizontal magnitude
    if (px != 0 || py != 0) begin
      a     = px;
      b     = py;
      start = '0;
      // Pre-rotate the left half plane by a quarter turn
      if (px < 0) begin
        if (py >= 0) begin
          a     = py;
          b     = -px;
          start = QTURN;
        end else begin
          a     = -py;
          b     = px;
          start = 32'd0 - QTURN;
        end
      end
      lon = cordic_vectoring(a, b, start);
      u   = a;
      mag = longint'((u >> 32) * INV_GAIN + (((u & 64'hFFFF_FFFF) * INV_GAIN) >> 32));
    end
    // Pass two: latitude from gain-corrected magnitude and z
    if (px != 0 || py != 0 || pz != 0) begin
      a   = mag;
      b   = pz;
      lat = cordic_vectoring(a, b, 32'd0);
    end
    r.lon  = round_angle(lon);
    r.lat  = round_angle(lat);
    r.last = last;
    return r;
  endfunction

  function automatic coord_t rand_coord();
    int s;
    s = int'($urandom_range(32)) - 16;
    case ($urandom_range(9))
      0:       return '0;
      1:       return coord_t'(s);
      2:       return C_MIN;
      3:       return C_MAX;
      default: return coord_t'($urandom());
    endcase
  endfunction

  // Offer one point, hold it until the transfer, then record its prediction
  task automatic send_point(coord_t x, coord_t y, coord_t z, logic last);
    while (src_idle_en && $urandom_range(99) < 38) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= S_DATA_W'({z, y, x});
    s_last  <= last;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    pending_angles.push_back(predict_spherical(x, y, z, last));
    points_sent++;
    @(negedge clk_i);
  endtask

  task automatic random_points(int n);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(), rand_coord(), rand_coord(), logic'($urandom_range(1)));
  endtask

  // Axis extremes, origins, both half-planes and the pi wrap
  task automatic test_directed_extremes();
    send_point('0, '0, '0, 1'b0);
    send_point('0, '0, C_MAX, 1'b1);
    send_point('0, '0, C_MIN, 1'b0);
    send_point('0, '0, 1, 1'b0);
    send_point(C_MAX, '0, '0, 1'b0);
    send_point(C_MIN, '0, '0, 1'b0);
    send_point('0, C_MAX, '0, 1'b0);
    send_point('0, C_MIN, '0, 1'b0);
    send_point(-1, 1, '0, 1'b0);
    send_point(-1, -1, '0, 1'b0);
    send_point(1, -1, 5, 1'b1);
    send_point(C_MAX, C_MAX, C_MAX, 1'b0);
    send_point(C_MIN, C_MIN, C_MIN, 1'b0);
    send_point(C_MIN, C_MAX, C_MIN, 1'b0);
    send_point(C_MAX, C_MIN, C_MAX, 1'b1);
    send_point(1, '0, '0, 1'b0);
    send_point(1, '0, C_MIN, 1'b0);
    send_point(-1, '0, -1, 1'b0);
    send_point(C_MIN, -1, '0, 1'b0);
    send_point('0, 1, C_MAX, 1'b1);
    send_point(3, 4, 5, 1'b0);
    send_point('0, -1, '0, 1'b1);
  endtask

  // Back-to-back transfers on both sides
  task automatic test_random_no_idle();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    random_points(300);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  task automatic test_random_with_idle();
    random_points(900);
  endtask

  // Sink holds off while the source keeps offering, filling the pipeline
  task automatic test_output_backpressure();
    src_idle_en  = 1'b0;
    hold_request = 1'b1;
    random_points(250);
    src_idle_en  = 1'b1;
  endtask

  // Sink ready: random idling plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_OFF;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_ready  <= 1'b0;
    end else begin
      m_ready  <= !(sink_idle_en && $urandom_range(99) < 38);
    end
  end

  // Compare each output transfer with the oldest prediction
  always @(posedge clk_i) begin
    sph_result_t want;
    if (rst_n && m_valid && m_ready) begin
      if (pending_angles.size() == 0) begin
        $error("unexpected result: longitude %0d latitude %0d last %0b",
               angle_t'(m_data[AW-1:0]), angle_t'(m_data[2*AW-1:AW]), m_last);
        errors++;
      end else begin
        want = pending_angles.pop_front();
        results_seen++;
        if (angle_t'(m_data[AW-1:0]) !== want.lon) begin
          $error("longitude: expected %0d, got %0d", want.lon, angle_t'(m_data[AW-1:0]));
          errors++;
        end
        if (angle_t'(m_data[2*AW-1:AW]) !== want.lat) begin
          $error("latitude: expected %0d, got %0d", want.lat, angle_t'(m_data[2*AW-1:AW]));
          errors++;
        end
        if (m_last !== want.last) begin
          $error("last_result: expected %0b, got %0b", want.last, m_last);
          errors++;
        end
      end
    end
  end

  // Count input stalls; end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_n && s_valid && !s_ready) input_stalls++;
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    test_directed_extremes();
    test_random_no_idle();
    test_random_with_idle();
    test_output_backpressure();
    s_valid <= 1'b0;

    // Drain outstanding results, then watch for stray transfers
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (2*LATENCY) @(posedge clk_i);

    $display("Converted %0d points (directed extremes, random with and without gaps,",
             points_sent);
    $display("a %0d-cycle sink hold-off); %0d results checked, %0d input stall cycles.",
             HOLD_OFF, results_seen, input_stalls);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cts_pkg.sv
rtl/core/cts_cell.sv
rtl/core/cts_gain.sv
rtl/core/cartesian_to_spherical_top.sv
sim/tb_top.sv
